### hw/rtl/knn_pkg.sv
`default_nettype none
package knn_pkg;

  localparam int DEF_MAX_REFERENCES = 1024;
  localparam int DEF_MAX_DIMENSIONS = 64;
  localparam int DEF_MAX_K          = 16;
  localparam int DEF_NUM_CLASSES    = 3;

  localparam int DIST_W      = 40;
  localparam int SUM_W       = 44;
  localparam int SCORE_W     = 48;
  localparam int SCALE_SHIFT = 40;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [4:0]  RESET_K    = 5'd5;
  localparam logic [10:0] RESET_REFS = 11'd0;
  localparam logic [6:0]  RESET_DIMS = 7'd64;

  typedef enum logic [1:0] {
    REG_K    = 2'd0,
    REG_REFS = 2'd1,
    REG_DIMS = 2'd2
  } knn_reg_t;

  typedef struct packed {
    logic               action;
    logic [9:0]         reference_index;
    logic [5:0]         element_index;
    logic signed [15:0] element_value;
    logic [1:0]         reference_class;
    logic [31:0]        query_id;
    logic               last_element;
  } knn_item_t;

  typedef struct packed {
    logic [31:0]        result_query_id;
    logic [1:0]         predicted_class;
    logic [SCORE_W-1:0] vote_score;
    logic [4:0]         winning_votes;
  } knn_result_t;

  typedef struct packed {
    logic [4:0]  k_neighbours;
    logic [10:0] reference_count;
    logic [6:0]  dimension_count;
  } knn_cfg_t;

  typedef struct packed {
    logic init;
    logic ref_clear;
    logic stream;
    logic offer;
    logic ptr_clear;
    logic ptr_run;
    logic scan;
    logic tally;
    logic ref_next;
    logic div_load;
    logic div_step;
    logic class_cmp;
    logic class_next;
    logic finish;
  } knn_cmd_t;

  typedef struct packed {
    logic refs_done;
    logic stream_done;
    logic offer_scan;
    logic ptr_done;
    logic sum_zero;
    logic div_done;
    logic class_last;
  } knn_status_t;

endpackage
`default_nettype wire

### hw/rtl/knn_ctrl.sv
`default_nettype none
module knn_ctrl import knn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        launch,
  input  knn_status_t status,
  output knn_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [3:0] {
    S_IDLE, S_REF, S_DIST, S_OFFER, S_SCAN, S_NEXT,
    S_TALLY, S_CHECK, S_DIV, S_CMP, S_CNEXT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (launch) begin
          cmd.init = 1'b1;
          state_next = S_REF;
        end
      end
      S_REF: begin
        if (status.refs_done) begin
          cmd.ptr_clear = 1'b1;
          state_next = S_TALLY;
        end else begin
          cmd.ref_clear = 1'b1;
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.stream = 1'b1;
        if (status.stream_done) state_next = S_OFFER;
      end
      S_OFFER: begin
        cmd.offer = 1'b1;
        if (status.offer_scan) begin
          // The heap just filled or lost its top, so find the new largest entry.
          cmd.ptr_clear = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_SCAN: begin
        cmd.ptr_run = 1'b1;
        cmd.scan = 1'b1;
        if (status.ptr_done) state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.ref_next = 1'b1;
        state_next = S_REF;
      end
      S_TALLY: begin
        cmd.ptr_run = 1'b1;
        cmd.tally = 1'b1;
        if (status.ptr_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.sum_zero) begin
          state_next = S_CNEXT;
        end else begin
          cmd.div_load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) state_next = S_CMP;
        else cmd.div_step = 1'b1;
      end
      S_CMP: begin
        cmd.class_cmp = 1'b1;
        state_next = S_CNEXT;
      end
      S_CNEXT: begin
        if (status.class_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.class_next = 1'b1;
          state_next = S_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= cmd.finish;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_busy_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("classification ended without a result beat");
  a_busy_while_working: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> busy)
    else $error("busy low while the sequencer is active");

endmodule
`default_nettype wire

### hw/rtl/knn_dp.sv
`default_nettype none
module knn_dp import knn_pkg::*; #(
  parameter int MAX_REFERENCES = DEF_MAX_REFERENCES,
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
  parameter int MAX_K          = DEF_MAX_K,
  parameter int NUM_CLASSES    = DEF_NUM_CLASSES
) (
  input  logic        clk,
  input  logic        rst,
  input  knn_cfg_t    cfg,
  input  logic        accept,
  input  knn_item_t   item,
  input  knn_cmd_t    cmd,
  output knn_status_t status,
  output knn_result_t result
);

  localparam int RW   = $clog2(MAX_REFERENCES + 1);
  localparam int RAW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int DW   = $clog2(MAX_DIMENSIONS + 1);
  localparam int DAW  = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int KW   = $clog2(MAX_K + 1);
  localparam int KAW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CAW  = $clog2(NUM_CLASSES);
  localparam int REF_DEPTH = MAX_REFERENCES * (2 ** DAW);
  localparam int NW   = 2 * KW + SCALE_SHIFT;
  localparam int DCW  = $clog2(NW + 1);
  localparam int QW   = NW + SCORE_W;

  // Register values clamped to the sizes of the stores.
  logic [RW-1:0] refs;
  logic [DW-1:0] dims;
  logic [KW-1:0] k;
  assign refs = (32'(cfg.reference_count) > MAX_REFERENCES) ? RW'(MAX_REFERENCES)
                                                             : RW'(cfg.reference_count);
  assign dims = (32'(cfg.dimension_count) > MAX_DIMENSIONS) ? DW'(MAX_DIMENSIONS)
                                                             : DW'(cfg.dimension_count);
  assign k    = (32'(cfg.k_neighbours) > MAX_K) ? KW'(MAX_K) : KW'(cfg.k_neighbours);

  // Reference and query stores.
  logic [15:0] ref_mem [REF_DEPTH];
  logic [1:0]  lab_mem [MAX_REFERENCES];
  logic [15:0] qry_mem [MAX_DIMENSIONS];

  logic [31:0] ri_w, ei_w;
  logic        load_ok, qry_ok;
  assign ri_w    = 32'(item.reference_index);
  assign ei_w    = 32'(item.element_index);
  assign load_ok = accept && !item.action && (ri_w < MAX_REFERENCES) && (ei_w < MAX_DIMENSIONS);
  assign qry_ok  = accept && item.action && (ei_w < MAX_DIMENSIONS);

  logic [RW-1:0] r_idx;
  logic [DW-1:0] e_idx;
  logic          issue, v1, v2;
  logic [15:0]   ref_q, qry_q;
  logic [1:0]    lab_q;
  logic [33:0]   sq;
  logic [DIST_W-1:0] acc;
  logic signed [16:0] diff;
  logic [16:0]   mag;
  logic [DIST_W:0] acc_sum;

  assign issue = cmd.stream && (e_idx < dims);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      ref_mem[{ri_w[RAW-1:0], ei_w[DAW-1:0]}] <= item.element_value;
      lab_mem[ri_w[RAW-1:0]] <= item.reference_class;
    end
    if (qry_ok) qry_mem[ei_w[DAW-1:0]] <= item.element_value;
    if (issue) begin
      ref_q <= ref_mem[{r_idx[RAW-1:0], e_idx[DAW-1:0]}];
      qry_q <= qry_mem[e_idx[DAW-1:0]];
    end
    lab_q <= lab_mem[r_idx[RAW-1:0]];
  end

  assign diff    = $signed({qry_q[15], qry_q}) - $signed({ref_q[15], ref_q});
  assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc_sum = {1'b0, acc} + (DIST_W + 1)'(sq);

  always_ff @(posedge clk) begin
    sq <= mag * mag;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      e_idx <= '0;
      r_idx <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (cmd.ref_clear) e_idx <= '0;
      else if (issue) e_idx <= e_idx + DW'(1);
      if (cmd.init) r_idx <= '0;
      else if (cmd.ref_next) r_idx <= r_idx + RW'(1);
    end
    if (cmd.ref_clear) acc <= '0;
    else if (v2) acc <= (acc_sum > {1'b0, DIST_MAX}) ? DIST_MAX : acc_sum[DIST_W-1:0];
  end

  // Neighbor heap: k slots, with the largest entry tracked by a scan.
  logic [DIST_W-1:0] nd [MAX_K];
  logic [1:0]        nl [MAX_K];
  logic [KW-1:0]     kept, ni;
  logic [KAW-1:0]    top_idx, ni_q;
  logic [DIST_W-1:0] top_dist, nd_q;
  logic [1:0]        nl_q;
  logic              fill, repl, rd, nv;

  assign fill = (k != '0) && (kept < k);
  assign repl = (k != '0) && (kept == k) && (acc < top_dist);
  assign rd   = cmd.ptr_run && (ni < kept);

  always_ff @(posedge clk) begin
    if (cmd.offer && fill) begin
      nd[kept[KAW-1:0]] <= acc;
      nl[kept[KAW-1:0]] <= lab_q;
    end else if (cmd.offer && repl) begin
      nd[top_idx] <= acc;
      nl[top_idx] <= lab_q;
    end
    if (rd) begin
      nd_q <= nd[ni[KAW-1:0]];
      nl_q <= nl[ni[KAW-1:0]];
      ni_q <= ni[KAW-1:0];
    end
    if (rst) begin
      kept <= '0;
      ni   <= '0;
      nv   <= 1'b0;
    end else begin
      if (cmd.init) kept <= '0;
      else if (cmd.offer && fill) kept <= kept + KW'(1);
      if (cmd.ptr_clear) ni <= '0;
      else if (rd) ni <= ni + KW'(1);
      nv <= rd;
    end
    // Strict compare keeps the lowest slot among equal largest distances.
    if (cmd.ptr_clear) begin
      top_dist <= '0;
      top_idx  <= '0;
    end else if (cmd.scan && nv && (nd_q > top_dist)) begin
      top_dist <= nd_q;
      top_idx  <= ni_q;
    end
  end

  // Per-class tally and scoring.
  logic [KW-1:0]    cnt [NUM_CLASSES];
  logic [SUM_W-1:0] sum [NUM_CLASSES];
  logic [31:0]      lab_w;
  logic             lab_ok;
  logic [CAW-1:0]   c_idx, ca;
  logic [KW-1:0]    cnt_rd;
  logic [SUM_W-1:0] sum_rd;
  logic [SUM_W:0]   sum_add;

  assign lab_w   = 32'(nl_q);
  assign lab_ok  = lab_w < NUM_CLASSES;
  assign ca      = cmd.tally ? lab_w[CAW-1:0] : c_idx;
  assign cnt_rd  = cnt[ca];
  assign sum_rd  = sum[ca];
  assign sum_add = {1'b0, sum_rd} + (SUM_W + 1)'(nd_q);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt[i] <= '0;
        sum[i] <= '0;
      end
    end else if (cmd.tally && nv && lab_ok) begin
      cnt[ca] <= cnt_rd + KW'(1);
      sum[ca] <= (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [NW-1:0]      dq;
  logic [SUM_W-1:0]   rem, dvs;
  logic [DCW-1:0]     dcnt;
  logic [SUM_W:0]     rem_sh, rem_sub;
  logic               ge;
  logic [2*KW-1:0]    cnt_sq;
  logic [QW-1:0]      q_wide;
  logic [SCORE_W-1:0] q_sat;
  logic [KW-1:0]      votes_c, best_votes;
  logic [SCORE_W-1:0] best_score;
  logic [CAW-1:0]     best_c;
  logic               scored;
  logic [31:0]        qid;

  assign cnt_sq  = cnt_rd * cnt_rd;
  assign rem_sh  = {rem, dq[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign q_wide  = QW'(dq);
  assign q_sat   = (q_wide > QW'(SCORE_MAX)) ? SCORE_MAX : q_wide[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq      <= {cnt_sq, {SCALE_SHIFT{1'b0}}};
      rem     <= '0;
      dvs     <= sum_rd;
      votes_c <= cnt_rd;
    end else if (cmd.div_step) begin
      dq  <= {dq[NW-2:0], ge};
      rem <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
    end
    if (cmd.init) qid <= item.query_id;
    if (cmd.finish) begin
      result.result_query_id <= qid;
      result.predicted_class <= scored ? 2'(best_c) : 2'd0;
      result.vote_score      <= best_score;
      result.winning_votes   <= scored ? 5'(best_votes) : 5'd0;
    end
    if (rst) begin
      dcnt  <= '0;
      c_idx <= '0;
    end else begin
      if (cmd.div_load) dcnt <= DCW'(NW);
      else if (cmd.div_step) dcnt <= dcnt - DCW'(1);
      if (cmd.init) c_idx <= '0;
      else if (cmd.class_next) c_idx <= c_idx + CAW'(1);
    end
    if (cmd.init) begin
      best_score <= '0;
      best_c     <= '0;
      best_votes <= '0;
      scored     <= 1'b0;
    end else if (cmd.class_cmp && (q_sat > best_score)) begin
      best_score <= q_sat;
      best_c     <= c_idx;
      best_votes <= votes_c;
      scored     <= 1'b1;
    end
  end

  assign status.refs_done   = (r_idx == refs);
  assign status.stream_done = (e_idx == dims) && !v1 && !v2;
  assign status.offer_scan  = fill ? ((kept + KW'(1)) == k) : repl;
  assign status.ptr_done    = (ni == kept) && !nv;
  assign status.sum_zero    = (sum_rd == '0);
  assign status.div_done    = (dcnt == '0);
  assign status.class_last  = (c_idx == CAW'(NUM_CLASSES - 1));

endmodule
`default_nettype wire

### hw/rtl/knn_weighted_vote_classifier.sv
// Channel   Handshake                      Payload
// input     start, busy (accept: start&!busy) item   (knn_item_t)
// result    done strobe, one cycle         result (knn_result_t)
// config    APB write/read, pready high    pwdata / prdata
//
// A load element or a query element without last_element does not raise busy.
// A classification keeps busy high through the distance walk through the
// reference memory port, each heap rescan, the tally and, for each class with
// a nonzero distance sum, the one-bit-per-cycle divider.
// Reset is synchronous; stores need no clearing pass.
// The result beat comes with busy falling; the receiver cannot stall.
`default_nettype none
module knn_weighted_vote_classifier import knn_pkg::*; #(
  parameter int MAX_REFERENCES = DEF_MAX_REFERENCES,
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
  parameter int MAX_K          = DEF_MAX_K,
  parameter int NUM_CLASSES    = DEF_NUM_CLASSES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  knn_item_t   item,
  output logic        done,
  output knn_result_t result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  knn_cfg_t    cfg;
  knn_cmd_t    cmd;
  knn_status_t status;
  knn_reg_t    reg_sel;
  logic        accept, launch, wr;

  assign accept  = start && !busy;
  assign launch  = accept && item.action && item.last_element;
  assign reg_sel = knn_reg_t'(paddr[3:2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k_neighbours    <= RESET_K;
      cfg.reference_count <= RESET_REFS;
      cfg.dimension_count <= RESET_DIMS;
    end else if (wr) begin
      case (reg_sel)
        REG_K:    cfg.k_neighbours    <= pwdata[4:0];
        REG_REFS: cfg.reference_count <= pwdata[10:0];
        REG_DIMS: cfg.dimension_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_K:    prdata = 32'(cfg.k_neighbours);
      REG_REFS: prdata = 32'(cfg.reference_count);
      REG_DIMS: prdata = 32'(cfg.dimension_count);
      default:  prdata = '0;
    endcase
  end

  knn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  knn_dp #(
    .MAX_REFERENCES (MAX_REFERENCES),
    .MAX_DIMENSIONS (MAX_DIMENSIONS),
    .MAX_K          (MAX_K),
    .NUM_CLASSES    (NUM_CLASSES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
`default_nettype wire

### tb/knn_weighted_vote_classifier_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module knn_weighted_vote_classifier_tb;
  import knn_pkg::*;

  localparam longint unsigned DIST_CAP  = (64'd1 << 40) - 1;
  localparam longint unsigned SUM_CAP   = (64'd1 << 44) - 1;
  localparam longint unsigned SCORE_CAP = (64'd1 << 48) - 1;
  localparam int RANDOM_ITEMS = 580;
  localparam int CYCLE_LIMIT  = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  knn_item_t   item = '0;
  logic        done;
  knn_result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  knn_weighted_vote_classifier uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's stores and registers.
  logic [15:0] ref_mem [0:1023][0:63];
  logic [1:0]  ref_label [0:1023];
  logic [15:0] query_mem [0:63];
  int unsigned k_reg = 5;
  int unsigned refs_reg = 0;
  int unsigned dims_reg = 64;

  knn_result_t pending_votes[$];
  int mismatches = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int cycles = 0;
  int gap_pct = 0;

  function automatic knn_result_t classify_query(logic [31:0] qid);
    int unsigned nrefs, ndims, nk, kept, top;
    longint unsigned ref_dist, q, best_score;
    longint unsigned heap_dist [16];
    logic [1:0] heap_label [16];
    int unsigned cnt [3];
    longint unsigned sums [3];
    int diff, mag;
    int unsigned best;
    bit scored;
    knn_result_t res;
    nrefs = refs_reg > 1024 ? 1024 : refs_reg;
    ndims = dims_reg > 64 ? 64 : dims_reg;
    nk = k_reg > 16 ? 16 : k_reg;
    kept = 0;
    for (int r = 0; r < nrefs; r++) begin
      ref_dist = 0;
      for (int e = 0; e < ndims; e++) begin
        diff = int'($signed(query_mem[e])) - int'($signed(ref_mem[r][e]));
        mag = diff < 0 ? -diff : diff;
        ref_dist += longint'(mag) * longint'(mag);
        if (ref_dist > DIST_CAP) ref_dist = DIST_CAP;
      end
      if (nk == 0) continue;
      if (kept < nk) begin
        heap_dist[kept] = ref_dist;
        heap_label[kept] = ref_label[r];
        kept++;
      end else begin
        top = 0;
        for (int i = 1; i < kept; i++)
          if (heap_dist[i] > heap_dist[top]) top = i;
        if (ref_dist < heap_dist[top]) begin
          heap_dist[top] = ref_dist;
          heap_label[top] = ref_label[r];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      cnt[c] = 0;
      sums[c] = 0;
    end
    for (int i = 0; i < kept; i++) begin
      if (heap_label[i] >= 3) continue;
      cnt[heap_label[i]]++;
      sums[heap_label[i]] += heap_dist[i];
      if (sums[heap_label[i]] > SUM_CAP) sums[heap_label[i]] = SUM_CAP;
    end
    best = 0;
    best_score = 0;
    scored = 0;
    for (int c = 0; c < 3; c++) begin
      if (sums[c] == 0) continue;
      q = (longint'(cnt[c] * cnt[c]) << 40) / sums[c];
      if (q > SCORE_CAP) q = SCORE_CAP;
      if (q > best_score) begin
        best_score = q;
        best = c;
        scored = 1;
      end
    end
    res.result_query_id = qid;
    res.predicted_class = scored ? best[1:0] : 2'd0;
    res.vote_score = best_score[47:0];
    res.winning_votes = scored ? cnt[best][4:0] : 5'd0;
    return res;
  endfunction

  // Updates the shadow stores; returns 1 when the item yields a result.
  function automatic bit absorb_item(knn_item_t it);
    if (it.action == 1'b0) begin
      ref_mem[it.reference_index][it.element_index] = it.element_value;
      ref_label[it.reference_index] = it.reference_class;
      return 0;
    end
    query_mem[it.element_index] = it.element_value;
    return it.last_element;
  endfunction

  // Drives one item, waits for it to be taken and queues what it should yield.
  task automatic send_item(knn_item_t it, bit typed = 0, knn_result_t typed_res = '0);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    if (absorb_item(it)) begin
      queries_sent++;
      pending_votes.insert(pending_votes.size(),
                           typed ? typed_res : classify_query(it.query_id));
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_votes.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(knn_reg_t idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_K:    k_reg = value & 32'h1f;
      REG_REFS: refs_reg = value & 32'h7ff;
      REG_DIMS: dims_reg = value & 32'h7f;
      default: ;
    endcase
  endtask

  function automatic knn_item_t make_item(bit act, int unsigned ri, int unsigned ei,
                                          logic [15:0] val, int unsigned cls,
                                          logic [31:0] qid, bit last);
    knn_item_t it;
    it.action = act;
    it.reference_index = ri[9:0];
    it.element_index = ei[5:0];
    it.element_value = val;
    it.reference_class = cls[1:0];
    it.query_id = qid;
    it.last_element = last;
    return it;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  typedef struct {
    bit          is_cfg;
    knn_reg_t    idx;
    int unsigned value;
    knn_item_t   it;
    bit          typed;
    knn_result_t res;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic void add_cfg(knn_reg_t idx, int unsigned value);
    stim_row_t row;
    row = '{1'b1, idx, value, '0, 1'b0, '0};
    directed.insert(directed.size(), row);
  endfunction

  function automatic void add_beat(knn_item_t it, bit typed = 0, knn_result_t res = '0);
    stim_row_t row;
    row = '{1'b0, REG_K, 0, it, typed, res};
    directed.insert(directed.size(), row);
  endfunction

  always @(posedge clk) begin
    knn_result_t exp_res;
    if (!rst && done) begin
      results_seen++;
      if (pending_votes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", result);
      end else begin
        exp_res = pending_votes.pop_front();
        if (result.result_query_id !== exp_res.result_query_id ||
            result.predicted_class !== exp_res.predicted_class ||
            result.vote_score !== exp_res.vote_score ||
            result.winning_votes !== exp_res.winning_votes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", exp_res, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int rnd_items, phase, nrefs, ndims, nq, cls;
    int unsigned kval, refs_val, dims_val;
    bit big;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With no references in use, with k of zero and with zero
    // dimensions no class can score, so those rows carry their answer.
    add_beat(make_item(1, 0, 0, 16'h1234, 0, 32'hffffffff, 1), 1,
             '{32'hffffffff, 2'd0, 48'd0, 5'd0});
    add_cfg(REG_K, 0);
    add_cfg(REG_REFS, 2);
    add_cfg(REG_DIMS, 1);
    add_beat(make_item(0, 0, 0, 16'h7fff, 1, 0, 0));
    add_beat(make_item(0, 1, 0, 16'h8000, 2, 0, 0));
    add_beat(make_item(1, 0, 0, 16'h0000, 0, 1, 1), 1, '{32'd1, 2'd0, 48'd0, 5'd0});
    add_cfg(REG_K, 31);
    add_beat(make_item(1, 0, 0, 16'h8000, 0, 2, 1));
    add_beat(make_item(1, 0, 0, 16'h0000, 0, 3, 1));
    // Label three holds a neighbour slot but never votes; last on a load is ignored.
    add_beat(make_item(0, 0, 0, 16'd100, 3, 0, 1));
    add_beat(make_item(1, 0, 0, 16'd100, 0, 4, 1));
    add_cfg(REG_DIMS, 0);
    add_beat(make_item(1, 0, 5, 16'h4000, 0, 5, 1), 1, '{32'd5, 2'd0, 48'd0, 5'd0});
    add_cfg(REG_DIMS, 1);
    add_cfg(REG_K, 1);
    add_beat(make_item(1, 0, 0, 16'd1, 0, 6, 0));
    add_beat(make_item(1, 0, 63, 16'hffff, 0, 7, 1));
    add_beat(make_item(0, 1, 0, 16'd1, 0, 0, 0));
    add_beat(make_item(1, 0, 0, 16'd0, 0, 8, 1));
    add_cfg(REG_K, 16);
    add_beat(make_item(1, 0, 0, 16'd0, 0, 9, 1));
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_item(directed[i].it, directed[i].typed, directed[i].res);
      end
    end

    // Random part: each phase loads every reference in use, then runs
    // complete queries with loads and stray elements mixed in.
    rnd_items = 0;
    phase = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      gap_pct = rnd_items < RANDOM_ITEMS / 3 ? 26 :
                rnd_items < 2 * RANDOM_ITEMS / 3 ? 85 : 0;
      big = (phase == 2);
      case ($urandom_range(9))
        0: kval = 0;
        1: kval = 31;
        2: kval = 16;
        default: kval = $urandom_range(1, 16);
      endcase
      refs_val = $urandom_range(1, 12);
      dims_val = $urandom_range(1, 8);
      if (big) begin
        refs_val = 200;
        dims_val = 1;
        kval = 16;
      end else if (phase == 4) begin
        refs_val = 2;
        dims_val = 127;
      end
      wait_idle();
      write_reg(REG_K, kval);
      write_reg(REG_REFS, refs_val);
      write_reg(REG_DIMS, dims_val);
      nrefs = refs_val > 1024 ? 1024 : refs_val;
      ndims = dims_val > 64 ? 64 : dims_val;
      for (int r = 0; r < nrefs; r++) begin
        cls = $urandom_range(7) == 0 ? 3 : $urandom_range(2);
        for (int e = 0; e < ndims; e++) begin
          send_item(make_item(0, r, e, pick_value(), cls, $urandom(), $urandom_range(1)));
          rnd_items++;
        end
      end
      nq = big ? 2 : (phase == 4) ? 1 : $urandom_range(3, 6);
      for (int qn = 0; qn < nq; qn++) begin
        for (int e = 0; e < ndims; e++) begin
          if ($urandom_range(3) == 0) begin
            send_item(make_item($urandom_range(1), $urandom_range(1023),
                                $urandom_range(63), pick_value(), $urandom_range(3),
                                $urandom(), 0));
            rnd_items++;
          end
          send_item(make_item(1, $urandom_range(1023), e, pick_value(), $urandom_range(3),
                              $urandom(), e == ndims - 1));
          rnd_items++;
        end
        // Every query element is written by now, so any index may close a query.
        if ($urandom_range(3) == 0) begin
          send_item(make_item(1, 0, $urandom_range(63), pick_value(), 0, $urandom(), 1));
          rnd_items++;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d phases of register settings, %0d classifying queries, %0d results.",
             phase, queries_sent, results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_votes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hw/rtl/knn_pkg.sv
hw/rtl/knn_ctrl.sv
hw/rtl/knn_dp.sv
hw/rtl/knn_weighted_vote_classifier.sv
tb/knn_weighted_vote_classifier_tb.sv
